### rtl/core/sas_pkg.sv
// Shared types, widths, register codes and reset values of the sprite animation sequencer.
`default_nettype none

package sas_pkg;

  // Default sizing of the frame list
  localparam int unsigned MAX_FRAMES_DEF = 8;
  localparam int unsigned FRAME_BITS_DEF = 8;

  // Fixed field widths
  localparam int unsigned LIST_W  = 64;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned REP_W   = 9;
  localparam int unsigned CELL_W  = 11;
  localparam int unsigned SHEET_W = 13;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned SUM_W   = 17;   // accumulator plus elapsed ticks
  localparam int unsigned IDX_W   = 18;   // slot plus tick quotient
  localparam int unsigned RL_W    = 10;   // signed repeats left
  localparam int unsigned DVS_W   = 16;   // divisor / remainder width
  localparam int unsigned FNUM_W  = 8;
  localparam int unsigned SLOT_O_W = 3;
  localparam int unsigned SX_W    = 12;
  localparam int unsigned SY_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_DELAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TIMES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEET_WIDTH  = 3'd6;

  // Register reset values
  localparam logic [LIST_W-1:0]  RST_FRAME_LIST   = '0;
  localparam logic [CNT_W-1:0]   RST_FRAME_COUNT  = 4'd1;
  localparam logic [DELAY_W-1:0] RST_TICK_DELAY   = 16'd1;
  localparam logic [REP_W-1:0]   RST_REPEAT_TIMES = 9'h1FF;  // -1
  localparam logic [CELL_W-1:0]  RST_CELL_WIDTH   = 11'd16;
  localparam logic [CELL_W-1:0]  RST_CELL_HEIGHT  = 11'd16;
  localparam logic [SHEET_W-1:0] RST_SHEET_WIDTH  = 13'd256;

  localparam logic [RL_W-1:0] RL_FOREVER = 10'h3FF;          // -1
  localparam logic [SX_W-1:0] SX_MAX     = 12'hFFF;
  localparam logic [SY_W-1:0] SY_MAX     = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_TICK,
    ST_CHK_SLOT,
    ST_DIV_SLOT,
    ST_UPD_REP,
    ST_MUL_X,
    ST_DIV_SHEET,
    ST_MUL_Y,
    ST_OUT
  } sas_state_e;

endpackage

`default_nettype wire

### rtl/core/sprite_animation_sequencer.sv
// Top level of the sprite animation sequencer: sequencer around one shared divider.
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   elapsed_ticks_i
// out       output     out_valid_o/out_ready_i frame_number_o, slot_index_o, source_x_o,
//                                              source_y_o, finished_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One beat runs through IDLE, DIV_TICK, CHK_SLOT, MUL_X, DIV_SHEET, MUL_Y and OUT;
// a slot wrap adds DIV_SLOT and UPD_REP, a held or single-frame sprite skips the tick
// division. The beat is paced by the bit-serial restoring divider, one quotient
// bit per cycle, shared by the tick, slot and sheet divisions.
// Reset (async, active low) loads the register defaults and clears the sequence state.
// in_ready_o is high only between beats; a result waiting on out_ready_i does not block the
// next input, but the new result is held back until the output register is free.
// cfg_ready_o is always high; any write to a listed register restarts the sequence.

module sprite_animation_sequencer import sas_pkg::*; #(
  parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input items
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [TICK_W-1:0]    elapsed_ticks_i,
  // result items
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [FNUM_W-1:0]         frame_number_o,
  output logic [SLOT_O_W-1:0]       slot_index_o,
  output logic [SX_W-1:0]           source_x_o,
  output logic [SY_W-1:0]           source_y_o,
  output logic                      finished_o,
  // configuration writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [LIST_W-1:0]    cfg_data_i
);

  // Frame counts beyond what the 4-bit register can hold never occur
  localparam int unsigned CNT_MAX = (MAX_FRAMES < 15) ? MAX_FRAMES : 15;
  localparam int unsigned SLOT_W  = $clog2(CNT_MAX);
  localparam int unsigned SH_W    = $clog2(CNT_MAX * FRAME_BITS + 1);
  localparam int unsigned PW      = CELL_W + FRAME_BITS;        // cell_width * frame
  localparam int unsigned DW      = (PW > IDX_W) ? PW : IDX_W;  // divider dividend
  localparam int unsigned CW      = $clog2(DW + 1);             // step counter
  localparam int unsigned MW      = PW + CELL_W;                // shared multiplier result
  localparam int unsigned RW      = IDX_W + 2;                  // repeat difference
  localparam logic [SH_W-1:0] FB_SH = SH_W'(FRAME_BITS);

  // ---------------------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------------------
  sas_state_e state_q, state_d;
  logic [CW-1:0] cnt_q;

  // configuration
  logic [LIST_W-1:0]  frame_list_q;
  logic [CNT_W-1:0]   frame_count_q;
  logic [DELAY_W-1:0] tick_delay_q;
  logic [REP_W-1:0]   repeat_times_q;
  logic [CELL_W-1:0]  cell_width_q;
  logic [CELL_W-1:0]  cell_height_q;
  logic [SHEET_W-1:0] sheet_width_q;

  // sequence state
  logic [TICK_W-1:0]  tick_accum_q;
  logic [SLOT_W-1:0]  slot_pos_q;
  logic [RL_W-1:0]    repeats_left_q;
  logic               held_done_q;

  // shared divider
  logic [DW-1:0]      dvd_q;
  logic [DW-1:0]      quo_q;
  logic [DVS_W-1:0]   rem_q;
  logic [DVS_W-1:0]   dvs_q;

  // datapath
  logic [FRAME_BITS-1:0] frame_q;
  logic [MW-1:0]         prod_q;
  logic [SX_W-1:0]       sx_q;

  // output register
  logic                  out_valid_q;
  logic [FNUM_W-1:0]     frame_number_q;
  logic [SLOT_O_W-1:0]   slot_index_q;
  logic [SX_W-1:0]       source_x_q;
  logic [SY_W-1:0]       source_y_q;
  logic                  finished_q;

  // ---------------------------------------------------------------------------------------
  // Derived values
  // ---------------------------------------------------------------------------------------
  logic               in_acc;
  logic               out_load;
  logic               cfg_hit;
  logic [CNT_W-1:0]   cnt_use;
  logic               few_frames;
  logic [DELAY_W-1:0] delay_eff;
  logic [SHEET_W-1:0] sheet_eff;
  logic [SUM_W-1:0]   sum_in;
  logic [IDX_W-1:0]   idx;
  logic               wrap;
  logic [SLOT_W-1:0]  slot_use;
  logic [SH_W-1:0]    frame_sh;
  logic [FRAME_BITS-1:0] frame_sel;
  logic [RL_W-1:0]    rep_new;

  assign in_acc  = in_valid_i & in_ready_o;
  assign cfg_hit = cfg_valid_i & cfg_ready_o & (cfg_index_i <= CFG_SHEET_WIDTH);

  // frame counts above the build limit are clamped
  assign cnt_use    = (32'(frame_count_q) > MAX_FRAMES) ? CNT_W'(CNT_MAX) : frame_count_q;
  assign few_frames = (cnt_use < CNT_W'(2));
  // zero delay and zero sheet width behave as one
  assign delay_eff  = (tick_delay_q == '0) ? DELAY_W'(1) : tick_delay_q;
  assign sheet_eff  = (sheet_width_q == '0) ? SHEET_W'(1) : sheet_width_q;

  assign sum_in = SUM_W'(tick_accum_q) + SUM_W'(elapsed_ticks_i);

  // slot after the tick division; wraps when it reaches or passes the frame count
  assign idx  = IDX_W'(slot_pos_q) + quo_q[IDX_W-1:0];
  assign wrap = (idx >= IDX_W'(cnt_use));

  // single-frame sprites show slot 0 and leave the state alone
  assign slot_use = (held_done_q || !few_frames) ? slot_pos_q : '0;

  // slots past the end of the 64-bit list shift out to frame 0
  assign frame_sh  = SH_W'(slot_use) * FB_SH;
  assign frame_sel = FRAME_BITS'(frame_list_q >> frame_sh);

  // repeat count after a wrap: repeats_left - idx / count
  logic [RW-1:0] rep_diff;
  logic          rep_forever;
  logic          rep_hold;
  assign rep_diff    = {{(RW-RL_W){repeats_left_q[RL_W-1]}}, repeats_left_q}
                     - RW'(quo_q[IDX_W-1:0]);
  assign rep_forever = (repeats_left_q == RL_FOREVER);
  assign rep_hold    = !rep_forever && (rep_diff[RW-1] || (rep_diff == '0));

  assign rep_new = (cfg_index_i == CFG_REPEAT_TIMES)
                 ? {cfg_data_i[REP_W-1], cfg_data_i[REP_W-1:0]}
                 : {repeat_times_q[REP_W-1], repeat_times_q};

  // ---------------------------------------------------------------------------------------
  // Shared restoring divider step: one quotient bit per cycle, dividend fed MSB first
  // ---------------------------------------------------------------------------------------
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   trial_diff;
  logic             trial_ge;
  logic [DVS_W-1:0] rem_step;

  assign trial      = {rem_q, dvd_q[DW-1]};
  assign trial_ge   = (trial >= {1'b0, dvs_q});
  assign trial_diff = trial - {1'b0, dvs_q};
  assign rem_step   = trial_ge ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];

  // ---------------------------------------------------------------------------------------
  // Shared multiplier: cell_width * frame, then sheet row * cell_height
  // ---------------------------------------------------------------------------------------
  logic [PW-1:0]     mul_a;
  logic [CELL_W-1:0] mul_b;
  logic [MW-1:0]     mul_p;

  always_comb begin
    if (state_q == ST_MUL_X) begin
      mul_a = PW'(frame_sel);
      mul_b = cell_width_q;
    end else begin
      mul_a = quo_q[PW-1:0];
      mul_b = cell_height_q;
    end
  end

  assign mul_p = MW'(mul_a) * MW'(mul_b);

  // ---------------------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (held_done_q || few_frames) ? ST_MUL_X : ST_DIV_TICK;
        end
      end
      ST_DIV_TICK: begin
        if (cnt_q == CW'(1)) state_d = ST_CHK_SLOT;
      end
      ST_CHK_SLOT: begin
        state_d = wrap ? ST_DIV_SLOT : ST_MUL_X;
      end
      ST_DIV_SLOT: begin
        if (cnt_q == CW'(1)) state_d = ST_UPD_REP;
      end
      ST_UPD_REP:   state_d = ST_MUL_X;
      ST_MUL_X:     state_d = ST_DIV_SHEET;
      ST_DIV_SHEET: begin
        if (cnt_q == CW'(1)) state_d = ST_MUL_Y;
      end
      ST_MUL_Y:     state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // Sequencer: handshake outputs
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_OUT:  out_load   = !out_valid_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
        out_load   = 1'b0;
      end
    endcase
  end

  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------------------
  // Control and state registers
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      frame_list_q   <= RST_FRAME_LIST;
      frame_count_q  <= RST_FRAME_COUNT;
      tick_delay_q   <= RST_TICK_DELAY;
      repeat_times_q <= RST_REPEAT_TIMES;
      cell_width_q   <= RST_CELL_WIDTH;
      cell_height_q  <= RST_CELL_HEIGHT;
      sheet_width_q  <= RST_SHEET_WIDTH;
      tick_accum_q   <= '0;
      slot_pos_q     <= '0;
      repeats_left_q <= {RST_REPEAT_TIMES[REP_W-1], RST_REPEAT_TIMES};
      held_done_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      case (state_q)
        ST_IDLE:      if (in_acc) cnt_q <= CW'(SUM_W);
        ST_DIV_TICK,
        ST_DIV_SLOT,
        ST_DIV_SHEET: cnt_q <= cnt_q - CW'(1);
        ST_CHK_SLOT:  cnt_q <= CW'(IDX_W);
        ST_MUL_X:     cnt_q <= CW'(PW);
        default:      cnt_q <= cnt_q;
      endcase

      case (state_q)
        ST_CHK_SLOT: begin
          // remainder of the tick division stays in the accumulator
          tick_accum_q <= rem_q[TICK_W-1:0];
          if (!wrap) slot_pos_q <= idx[SLOT_W-1:0];
        end
        ST_UPD_REP: begin
          if (rep_hold) begin
            // repeats exhausted: hold the last frame until the next register write
            held_done_q    <= 1'b1;
            slot_pos_q     <= SLOT_W'(cnt_use - CNT_W'(1));
            tick_accum_q   <= '0;
            repeats_left_q <= '0;
          end else begin
            slot_pos_q <= rem_q[SLOT_W-1:0];
            if (!rep_forever) repeats_left_q <= rep_diff[RL_W-1:0];
          end
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // register writes are to land between beats (the block does not enforce this); they restart the sequence
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_FRAME_LIST:   frame_list_q   <= cfg_data_i;
          CFG_FRAME_COUNT:  frame_count_q  <= cfg_data_i[CNT_W-1:0];
          CFG_TICK_DELAY:   tick_delay_q   <= cfg_data_i[DELAY_W-1:0];
          CFG_REPEAT_TIMES: repeat_times_q <= cfg_data_i[REP_W-1:0];
          CFG_CELL_WIDTH:   cell_width_q   <= cfg_data_i[CELL_W-1:0];
          CFG_CELL_HEIGHT:  cell_height_q  <= cfg_data_i[CELL_W-1:0];
          CFG_SHEET_WIDTH:  sheet_width_q  <= cfg_data_i[SHEET_W-1:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        tick_accum_q   <= '0;
        slot_pos_q     <= '0;
        repeats_left_q <= rep_new;
        held_done_q    <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        // start (accumulator + ticks) / delay
        if (in_acc) begin
          dvd_q <= DW'(sum_in) << (DW - SUM_W);
          quo_q <= '0;
          rem_q <= '0;
          dvs_q <= delay_eff;
        end
      end
      ST_DIV_TICK,
      ST_DIV_SLOT,
      ST_DIV_SHEET: begin
        dvd_q <= dvd_q << 1;
        quo_q <= {quo_q[DW-2:0], trial_ge};
        rem_q <= rem_step;
      end
      ST_CHK_SLOT: begin
        // start slot / count
        dvd_q <= DW'(idx) << (DW - IDX_W);
        quo_q <= '0;
        rem_q <= '0;
        dvs_q <= DVS_W'(cnt_use);
      end
      ST_MUL_X: begin
        // start (cell_width * frame) / sheet_width
        frame_q <= frame_sel;
        dvd_q   <= DW'(mul_p[PW-1:0]) << (DW - PW);
        quo_q   <= '0;
        rem_q   <= '0;
        dvs_q   <= DVS_W'(sheet_eff);
      end
      ST_MUL_Y: begin
        prod_q <= mul_p;
        sx_q   <= (rem_q > DVS_W'(SX_MAX)) ? SX_MAX : rem_q[SX_W-1:0];
      end
      ST_OUT: begin
        if (out_load) begin
          frame_number_q <= FNUM_W'(frame_q);
          slot_index_q   <= SLOT_O_W'(slot_use);
          source_x_q     <= sx_q;
          source_y_q     <= (prod_q > MW'(SY_MAX)) ? SY_MAX : prod_q[SY_W-1:0];
          finished_q     <= held_done_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign frame_number_o = frame_number_q;
  assign slot_index_o   = slot_index_q;
  assign source_x_o     = source_x_q;
  assign source_y_o     = source_y_q;
  assign finished_o     = finished_q;

endmodule

`default_nettype wire

### rtl/core/sas_checker.sv
// Port-level checker for the sprite animation sequencer, bound to the top level.
`default_nettype none

module sas_checker import sas_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic [TICK_W-1:0]    elapsed_ticks_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [FNUM_W-1:0]    frame_number_o,
  input wire logic [SLOT_O_W-1:0]  slot_index_o,
  input wire logic [SX_W-1:0]      source_x_o,
  input wire logic [SY_W-1:0]      source_y_o,
  input wire logic                 finished_o,
  input wire logic                 cfg_valid_i,
  input wire logic                 cfg_ready_o,
  input wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input wire logic [LIST_W-1:0]    cfg_data_i
);

  // last held frame seen on the output, cleared by a register write
  logic                seen_q;
  logic [FNUM_W-1:0]   held_frame_q;
  logic [SLOT_O_W-1:0] held_slot_q;
  logic                out_acc;
  logic                cfg_acc;

  assign out_acc = out_valid_o & out_ready_i;
  assign cfg_acc = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      held_frame_q <= '0;
      held_slot_q  <= '0;
    end else if (cfg_acc) begin
      seen_q <= 1'b0;
    end else if (out_acc && finished_o) begin
      seen_q       <= 1'b1;
      held_frame_q <= frame_number_o;
      held_slot_q  <= slot_index_o;
    end
  end

  // one beat at a time: an accepted input drops ready
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("in_ready_o stayed high after an input beat");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(frame_number_o) && $stable(slot_index_o)
       && $stable(source_x_o) && $stable(source_y_o) && $stable(finished_o)))
    else $error("stalled result changed");

  // once held, the sprite keeps showing the same frame until reconfigured
  a_hold_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && seen_q) |->
      (finished_o && (frame_number_o == held_frame_q) && (slot_index_o == held_slot_q)))
    else $error("held frame released without a register write");

  // no result without an input beat in flight: a config write never makes one
  a_cfg_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && !out_valid_o && !in_valid_i) |=> !out_valid_o)
    else $error("result appeared without an input beat");

endmodule

bind sprite_animation_sequencer sas_checker u_sas_checker (.*);

`default_nettype wire
